// ===== design/oemd_pkg.sv =====
// ----------------------------------------------------------------------------
// oemd_pkg: shared types and constants of the order-execution message decoder
// Field layout, result kind codes, controller/datapath interface structs and
// the base-36 digit character helper.
// ----------------------------------------------------------------------------
`default_nettype none

package oemd_pkg;

  // Widths
  localparam int unsigned POS_W   = 9;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned NDIGITS = 13;
  localparam int unsigned DCNT_W  = 4;

  // Message layout (byte positions)
  localparam logic [POS_W-1:0] POS_OID_FIRST   = 9'd18;
  localparam logic [POS_W-1:0] POS_XID_FIRST   = 9'd38;
  localparam logic [POS_W-1:0] POS_XID_LAST    = 9'd45;
  localparam logic [POS_W-1:0] POS_FILL_FIRST  = 9'd46;
  localparam logic [POS_W-1:0] POS_FILL_LAST   = 9'd49;
  localparam logic [POS_W-1:0] POS_PRICE_FIRST = 9'd50;
  localparam logic [POS_W-1:0] POS_PRICE_LAST  = 9'd57;
  localparam logic [POS_W-1:0] POS_ACT_FIRST   = 9'd58;
  localparam logic [POS_W-1:0] POS_ACT_LAST    = 9'd61;
  localparam logic [POS_W-1:0] POS_LIQ         = 9'd66;
  localparam logic [POS_W-1:0] POS_GAP         = 9'd69;
  localparam logic [POS_W-1:0] POS_OPT_BASE    = 9'd70;
  localparam logic [POS_W-1:0] POS_MAX         = 9'd511;
  localparam int unsigned      OPT_LEN         = 14;
  localparam int unsigned      SYM_LEN         = 8;
  localparam int unsigned      MKT_END         = 12;

  localparam logic [7:0] CHAR_REMOVED = 8'h52;  // 'R'

  // Reciprocal of 36 for the byte-wise long division: q = (x * RECIP) >> 18,
  // exact for x below 36 * 256.
  localparam logic [12:0] RECIP36      = 13'd7282;
  localparam int unsigned RECIP_SHIFT  = 18;
  localparam int unsigned RADIX        = 36;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ORDER_ID  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_EXEC_ID   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_FILLED    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_PRICE     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ACTIVE    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_LIQUIDITY = 4'd5;
  localparam logic [KIND_W-1:0] KIND_SYMBOL    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_MARKET    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FEE       = 4'd8;

  // Controller -> datapath
  typedef struct packed {
    logic accept;      // latch the input item
    logic div_step;    // one byte step of the divide-by-36
    logic put_pend;    // move the pending result to the output register
    logic emit_digit;  // move the top buffered digit to the output register
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic res_valid;   // the offered byte yields a single result
    logic has_conv;    // the offered byte closes a nonzero execution id
    logic div_last;    // this step finishes one digit
    logic quo_zero;    // quotient after this step is zero
    logic out_free;    // output register can take a result this cycle
    logic last_digit;  // the digit about to be emitted is the final one
  } dp_sts_t;

  // Base-36 digit to ASCII
  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = 8'h30 + {2'b00, d};
    end else begin
      c = 8'h41 + {2'b00, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/oemd_ctrl.sv =====
// ----------------------------------------------------------------------------
// oemd_ctrl: sequencing of the decoder
// Takes one byte at a time, then hands its single result, if any, to the output
// register or runs the base-36 conversion and digit emission.
// ----------------------------------------------------------------------------
`default_nettype none

module oemd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire oemd_pkg::dp_sts_t  sts,
  output oemd_pkg::ctl_cmd_t      cmd
);
  import oemd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUT,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (sts.res_valid) begin
            state_nxt = ST_PUT;
          end else if (sts.has_conv) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_PUT: begin
        if (sts.out_free) begin
          cmd.put_pend = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last && sts.quo_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.last_digit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/oemd_datapath.sv =====
// ----------------------------------------------------------------------------
// oemd_datapath: field decode, accumulation, base-36 divider, output register
// Decodes the byte position, gathers little-endian numbers, divides the
// execution id by 36 one byte per cycle and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oemd_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_end_of_message,
  input  wire oemd_pkg::ctl_cmd_t            cmd,
  output oemd_pkg::dp_sts_t                  sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [oemd_pkg::KIND_W-1:0]        out_kind,
  output logic [oemd_pkg::VAL_W-1:0]         out_value,
  output logic                               out_last_of_run
);
  import oemd_pkg::*;

  // Message state
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   ostart_r;
  logic [VAL_W-1:0]   acc_r;
  // Pending single result
  logic [KIND_W-1:0]  pend_kind_r;
  logic [VAL_W-1:0]   pend_value_r;
  // Divider
  logic [VAL_W-1:0]   quo_r, quo_nxt;
  logic [DIGIT_W-1:0] rem_r;
  logic [2:0]         bidx_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [DIGIT_W-1:0] dbuf_r [NDIGITS];
  // Output register
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_last_r;

  // Region decode of the current byte position
  logic              in_oid, in_xid, in_fill, in_price, in_act, in_opt, in_num;
  logic [POS_W:0]    opt_end;
  logic [POS_W-1:0]  opt_off;
  logic [POS_W-1:0]  first, off;
  logic [2:0]        kk;
  logic [VAL_W-1:0]  acc_g;

  assign opt_end  = {1'b0, ostart_r} + (POS_W+1)'(OPT_LEN);
  assign opt_off  = pos_r - ostart_r;
  assign in_oid   = (pos_r >= POS_OID_FIRST)   && (pos_r < POS_XID_FIRST);
  assign in_xid   = (pos_r >= POS_XID_FIRST)   && (pos_r <= POS_XID_LAST);
  assign in_fill  = (pos_r >= POS_FILL_FIRST)  && (pos_r <= POS_FILL_LAST);
  assign in_price = (pos_r >= POS_PRICE_FIRST) && (pos_r <= POS_PRICE_LAST);
  assign in_act   = (pos_r >= POS_ACT_FIRST)   && (pos_r <= POS_ACT_LAST);
  assign in_opt   = (pos_r >= POS_OPT_BASE) && (pos_r >= ostart_r)
                    && ({1'b0, pos_r} < opt_end);
  assign in_num   = in_xid || in_fill || in_price || in_act;

  // Little-endian gather
  always_comb begin
    priority if (in_xid) begin
      first = POS_XID_FIRST;
    end else if (in_fill) begin
      first = POS_FILL_FIRST;
    end else if (in_price) begin
      first = POS_PRICE_FIRST;
    end else begin
      first = POS_ACT_FIRST;
    end
  end

  assign off   = pos_r - first;
  assign kk    = off[2:0];
  assign acc_g = ((kk == 3'd0) ? '0 : acc_r)
                 | ({{(VAL_W-8){1'b0}}, in_data_byte} << {kk, 3'b000});

  // Single-result decode
  logic              res_valid;
  logic [KIND_W-1:0] res_kind;
  logic [VAL_W-1:0]  res_value;

  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_ORDER_ID;
    res_value = {{(VAL_W-8){1'b0}}, in_data_byte};
    priority if (in_oid) begin
      res_valid = (in_data_byte != 8'd0);
    end else if (in_fill) begin
      res_valid = (pos_r == POS_FILL_LAST);
      res_kind  = KIND_FILLED;
      res_value = acc_g;
    end else if (in_price) begin
      res_valid = (pos_r == POS_PRICE_LAST);
      res_kind  = KIND_PRICE;
      res_value = acc_g;
    end else if (in_act) begin
      res_valid = (pos_r == POS_ACT_LAST);
      res_kind  = KIND_ACTIVE;
      res_value = acc_g;
    end else if (pos_r == POS_LIQ) begin
      res_valid = 1'b1;
      res_kind  = KIND_LIQUIDITY;
      res_value = {{(VAL_W-1){1'b0}}, (in_data_byte == CHAR_REMOVED)};
    end else if (in_opt) begin
      res_valid = (in_data_byte != 8'd0);
      if (opt_off < POS_W'(SYM_LEN)) begin
        res_kind = KIND_SYMBOL;
      end else if (opt_off < POS_W'(MKT_END)) begin
        res_kind = KIND_MARKET;
      end else begin
        res_kind = KIND_FEE;
      end
    end else begin
      res_valid = 1'b0;
    end
  end

  // One byte step of the divide-by-36: {rem, byte} / 36
  logic [13:0] dx;
  logic [26:0] dprod;
  logic [7:0]  dq;
  logic [13:0] dr;

  assign dx    = {rem_r, quo_r[{bidx_r, 3'b000} +: 8]};
  assign dprod = {13'd0, dx} * {14'd0, RECIP36};
  assign dq    = dprod[RECIP_SHIFT +: 8];
  assign dr    = dx - ({1'b0, dq, 5'b00000} + {4'b0000, dq, 2'b00});

  always_comb begin
    quo_nxt = quo_r;
    quo_nxt[{bidx_r, 3'b000} +: 8] = dq;
  end

  // Status
  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sts            = '0;
    sts.res_valid  = res_valid;
    sts.has_conv   = (pos_r == POS_XID_LAST) && (acc_g != '0);
    sts.div_last   = (bidx_r == 3'd0);
    sts.quo_zero   = (quo_r[VAL_W-1:8] == '0) && (dq == 8'd0);
    sts.out_free   = out_free;
    sts.last_digit = (dcnt_r == DCNT_W'(1));
  end

  // Message state and pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ostart_r <= '0;
      acc_r    <= '0;
    end else if (cmd.accept) begin
      if (in_end_of_message) begin
        pos_r <= '0;
        acc_r <= '0;
      end else begin
        if (pos_r != POS_MAX) begin
          pos_r <= pos_r + POS_W'(1);
        end
        if (in_num) begin
          acc_r <= acc_g;
        end
      end
      if (pos_r == POS_GAP) begin
        ostart_r <= POS_OPT_BASE + {1'b0, in_data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_kind_r  <= res_kind;
      pend_value_r <= res_value;
    end
  end

  // Divider and digit buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      bidx_r <= 3'd7;
      rem_r  <= '0;
    end else if (cmd.accept) begin
      dcnt_r <= '0;
      bidx_r <= 3'd7;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      bidx_r <= bidx_r - 3'd1;
      if (bidx_r == 3'd0) begin
        rem_r  <= '0;
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end else begin
        rem_r <= dr[DIGIT_W-1:0];
      end
    end else if (cmd.emit_digit) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      quo_r <= acc_g;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      if (bidx_r == 3'd0) begin
        dbuf_r[dcnt_r] <= dr[DIGIT_W-1:0];
      end
    end
  end

  // Output register
  logic [DCNT_W-1:0] top_idx;
  assign top_idx = dcnt_r - DCNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.put_pend || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_pend) begin
      out_kind_r  <= pend_kind_r;
      out_value_r <= pend_value_r;
      out_last_r  <= 1'b1;
    end else if (cmd.emit_digit) begin
      out_kind_r  <= KIND_EXEC_ID;
      out_value_r <= {{(VAL_W-8){1'b0}}, digit_char(dbuf_r[top_idx])};
      out_last_r  <= (dcnt_r == DCNT_W'(1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_value       = out_value_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

// ===== design/order_execution_message_decoder_core.sv =====
// ----------------------------------------------------------------------------
// order_execution_message_decoder_core: byte-serial order-execution decoder
// Emits tagged field results (order id chars, execution id in base 36,
// volumes, price, liquidity, symbol, market, fee code) as bytes arrive.
//
//   channel | ports                                           | direction
//   --------+-------------------------------------------------+----------
//   input   | in_valid in_ready in_data_byte in_end_of_message | in
//   result  | out_valid out_ready out_kind out_value           | out
//           | out_last_of_run                                  |
//
// A byte with no result leaves the controller idle; a byte with one result
// passes through the put state, which holds while the result register is full.
// The byte closing the execution id runs the divide-by-36 unit, one dividend
// byte per cycle for each digit, then emits the digits, up to 13 of them.
// Synchronous active-low reset; no clearing pass. A held result keeps the
// controller in its put or emit state with in_ready low; a byte is still
// taken while the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module order_execution_message_decoder_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_end_of_message,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [oemd_pkg::KIND_W-1:0]        out_kind,
  output logic [oemd_pkg::VAL_W-1:0]         out_value,
  output logic                               out_last_of_run
);
  import oemd_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  oemd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oemd_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

`default_nettype wire

// ===== design/oemd_checker.sv =====
// ----------------------------------------------------------------------------
// oemd_checker: port-level checks of the decoder
// Watches the result channel for held items and well-formed result values.
// ----------------------------------------------------------------------------
`default_nettype none

module oemd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [oemd_pkg::KIND_W-1:0]   out_kind,
  input wire logic [oemd_pkg::VAL_W-1:0]    out_value,
  input wire logic                          out_last_of_run
);
  import oemd_pkg::*;

  // A stalled item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_value) && $stable(out_last_of_run))
    else $error("result item changed while stalled");

  // Liquidity is a single flag bit
  a_liq_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_LIQUIDITY) |-> (out_value[VAL_W-1:1] == '0))
    else $error("liquidity value out of range");

  // Execution id digits are 0-9 or A-Z
  a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EXEC_ID) |->
      (out_value[VAL_W-1:8] == '0)
      && (((out_value[7:0] >= 8'h30) && (out_value[7:0] <= 8'h39))
       || ((out_value[7:0] >= 8'h41) && (out_value[7:0] <= 8'h5A))))
    else $error("bad base-36 digit character");

  // Text characters are nonzero bytes; no input taken while a digit run is out
  a_text_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_ORDER_ID) || (out_kind == KIND_SYMBOL)
      || (out_kind == KIND_MARKET) || (out_kind == KIND_FEE)) |->
      (out_value[VAL_W-1:8] == '0) && (out_value[7:0] != 8'd0))
    else $error("text result is not a nonzero character");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EXEC_ID) && !out_last_of_run && out_ready
      |-> !(in_valid && in_ready))
    else $error("input taken in the middle of a digit run");

endmodule

bind order_execution_message_decoder_core oemd_checker u_oemd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_value       (out_value),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire

// ===== bench/oemd_field_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oemd_field_checker: result checker for the order-execution message decoder
// Watches both channels, decodes every accepted input byte on its own copy of
// the message state, queues the field results it predicts and compares each
// accepted result against the oldest queued one.
// ----------------------------------------------------------------------------

module oemd_field_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_end_of_message,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [oemd_pkg::KIND_W-1:0] out_kind,
  input  wire logic [oemd_pkg::VAL_W-1:0]  out_value,
  input  wire logic                        out_last_of_run,
  output int                               mismatch_count,
  output int                               fields_pending,
  output int                               fields_checked
);
  import oemd_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    logic              last;
  } field_t;

  // expected field results, oldest first
  field_t field_q[$];
  // results of the byte being decoded
  field_t run_q[$];

  // decoder state
  int unsigned      msg_pos;
  int unsigned      opt_first;
  logic [VAL_W-1:0] num_acc;

  task automatic add_field(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value);
    field_t f;
    f.kind  = kind;
    f.value = value;
    f.last  = 1'b0;
    run_q.push_back(f);
  endtask

  // little-endian gather, restarting at the first byte of a field
  task automatic gather_le(input int unsigned p, input int unsigned first,
                           input logic [7:0] b);
    int unsigned k;
    k = (p - first) & 7;
    if (k == 0) num_acc = '0;
    num_acc = num_acc | ({56'd0, b} << (8 * k));
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eom);
    int unsigned      p;
    int unsigned      k;
    int               nd;
    logic [VAL_W-1:0] v;
    logic [5:0]       digs [NDIGITS];
    logic [7:0]       c;
    logic [KIND_W-1:0] okind;
    p = msg_pos;
    nd = 0;
    if (p >= POS_OID_FIRST && p < POS_XID_FIRST) begin
      if (b != 8'h00) add_field(KIND_ORDER_ID, {56'd0, b});
    end else if (p >= POS_XID_FIRST && p <= POS_XID_LAST) begin
      gather_le(p, POS_XID_FIRST, b);
      if (p == POS_XID_LAST) begin
        // base-36, least significant digit found first
        v = num_acc;
        while (v != 0 && nd < NDIGITS) begin
          digs[nd] = 6'(v % RADIX);
          v = v / RADIX;
          nd++;
        end
        for (int i = nd - 1; i >= 0; i--) begin
          if (digs[i] < 6'd10) c = 8'h30 + {2'b00, digs[i]};
          else c = 8'h41 + {2'b00, digs[i]} - 8'd10;
          add_field(KIND_EXEC_ID, {56'd0, c});
        end
      end
    end else if (p >= POS_FILL_FIRST && p <= POS_FILL_LAST) begin
      gather_le(p, POS_FILL_FIRST, b);
      if (p == POS_FILL_LAST) add_field(KIND_FILLED, num_acc);
    end else if (p >= POS_PRICE_FIRST && p <= POS_PRICE_LAST) begin
      gather_le(p, POS_PRICE_FIRST, b);
      if (p == POS_PRICE_LAST) add_field(KIND_PRICE, num_acc);
    end else if (p >= POS_ACT_FIRST && p <= POS_ACT_LAST) begin
      gather_le(p, POS_ACT_FIRST, b);
      if (p == POS_ACT_LAST) add_field(KIND_ACTIVE, num_acc);
    end else if (p == POS_LIQ) begin
      add_field(KIND_LIQUIDITY, (b == CHAR_REMOVED) ? 64'd1 : 64'd0);
    end else if (p == POS_GAP) begin
      opt_first = POS_OPT_BASE + b;
    end else if (p >= POS_OPT_BASE && p >= opt_first && p < opt_first + OPT_LEN) begin
      // symbol, market and fee code characters
      k = p - opt_first;
      if (k < SYM_LEN) okind = KIND_SYMBOL;
      else if (k < MKT_END) okind = KIND_MARKET;
      else okind = KIND_FEE;
      if (b != 8'h00) add_field(okind, {56'd0, b});
    end

    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    while (run_q.size() > 0) field_q.push_back(run_q.pop_front());

    if (eom) begin
      msg_pos = 0;
      num_acc = '0;
    end else if (msg_pos < POS_MAX) begin
      msg_pos = msg_pos + 1;
    end
  endtask

  task automatic report(input string what, input logic [VAL_W-1:0] want,
                        input logic [VAL_W-1:0] got);
    mismatch_count++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    field_t want;
    if (!rst_n) begin
      msg_pos   = 0;
      opt_first = 0;
      num_acc   = '0;
      field_q.delete();
      run_q.delete();
      fields_pending = 0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_data_byte, in_end_of_message);
      if (out_valid && out_ready) begin
        if (field_q.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected result, expected none, got kind %0d value %0h",
                   $time, out_kind, out_value);
        end else begin
          want = field_q.pop_front();
          fields_checked++;
          if (out_kind !== want.kind) report("kind", want.kind, out_kind);
          if (out_value !== want.value) report("value", want.value, out_value);
          if (out_last_of_run !== want.last)
            report("last_of_run", want.last, out_last_of_run);
        end
      end
      fields_pending = field_q.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for order_execution_message_decoder_core
// Sends a few hand-built order-execution messages (zero and full-width
// execution ids, removed and added liquidity, null text, end marker on a
// result byte) and then random whole, truncated and noise messages under
// several sender idle and receiver stall mixes. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_top;
  import oemd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 160;
  localparam int PHASE_BYTES  = 20;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_data_byte;
  logic              in_end_of_message;
  logic              out_valid;
  logic              out_ready;
  logic [KIND_W-1:0] out_kind;
  logic [VAL_W-1:0]  out_value;
  logic              out_last_of_run;

  int mismatch_count;
  int fields_pending;
  int fields_checked;

  int idle_pct;
  int stall_pct;
  int bytes_sent;
  int msgs_sent;
  int cycle_count;

  // message under construction
  logic [7:0] msg_q[$];

  order_execution_message_decoder_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_last_of_run   (out_last_of_run)
  );

  oemd_field_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_last_of_run   (out_last_of_run),
    .mismatch_count    (mismatch_count),
    .fields_pending    (fields_pending),
    .fields_checked    (fields_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("FAIL order_execution_message_decoder_core");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // one item; called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_data_byte      = b;
    in_end_of_message = eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // first len bytes of the message, end marker on the last one
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_byte(msg_q[i], i == len - 1);
    msgs_sent++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (fields_pending != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_exec_id();
    logic [63:0] x;
    case ($urandom_range(0, 9))
      0:       x = 64'd0;
      1:       x = '1;
      default: x = {$urandom(), $urandom()} >> $urandom_range(0, 63);
    endcase
    return x;
  endfunction

  // well-formed report with random content through the fee code
  task automatic build_report(input logic [63:0] xid, input logic [7:0] gap,
                              input int null_pct);
    int         total;
    logic [7:0] b;
    msg_q.delete();
    total = 84 + gap + $urandom_range(0, 4);
    for (int i = 0; i < total; i++) begin
      b = 8'($urandom_range(0, 255));
      if (((i >= 18 && i < 38) || i >= 70) && $urandom_range(0, 99) < null_pct) b = 8'h00;
      msg_q.push_back(b);
    end
    for (int k = 0; k < 8; k++) msg_q[38 + k] = xid[8 * k +: 8];
    b = 8'($urandom_range(0, 255));
    msg_q[66] = $urandom_range(0, 1) ? CHAR_REMOVED : b;
    msg_q[69] = gap;
  endtask

  task automatic random_traffic(input int budget);
    int         start;
    int         pick;
    int         len;
    logic [7:0] gap;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      gap  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, 40))
                                         : 8'($urandom_range(0, 6));
      build_report(rand_exec_id(), gap, 15);
      if (pick < 65) begin
        send_message(msg_q.size());
      end else if (pick < 88) begin
        send_message($urandom_range(1, msg_q.size()));
      end else begin
        len = $urandom_range(1, 24);
        msg_q.delete();
        repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
        send_message(len);
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = 8'h00;
    in_end_of_message = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed messages, no idling
    msg_q.delete();
    msg_q.push_back(8'hFF);
    send_message(1);

    // zero execution id, removed liquidity, no gap, some null text,
    // end marker on the last fee code byte
    build_report(64'd0, 8'd0, 30);
    msg_q[66] = CHAR_REMOVED;
    send_message(84);

    // widest execution id and numbers, added liquidity, end marker on the flag
    build_report('1, 8'd0, 0);
    msg_q[66] = 8'h00;
    for (int i = 46; i < 62; i++) msg_q[i] = 8'hFF;
    send_message(67);

    // sender holds off until every expected result is in
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      random_traffic(PHASE_BYTES);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d messages, checked %0d field results",
             bytes_sent, msgs_sent, fields_checked);
    $display("idle mixes: none, sender 55%%, receiver 55%%, both 27%%");
    if (fields_pending != 0)
      $display("%0d expected field results never arrived", fields_pending);
    if (mismatch_count == 0 && fields_pending == 0) begin
      $display("PASS order_execution_message_decoder_core");
    end else begin
      $display("FAIL order_execution_message_decoder_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/oemd_pkg.sv
design/oemd_ctrl.sv
design/oemd_datapath.sv
design/order_execution_message_decoder_core.sv
design/oemd_checker.sv
bench/oemd_field_checker.sv
bench/tb_top.sv
